/* design/msd_pkg.sv */
`default_nettype none

package msd_pkg;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam int DIGITS = 4;
    localparam logic [15:0] MAX_VALUE = 16'd9999;
    localparam logic [9:0] DWELL_RESET = 10'd5;

    localparam logic [13:0] RECIP_1000 = 14'd8389;
    localparam int SHIFT_1000 = 23;
    localparam logic [13:0] RECIP_100 = 14'd5243;
    localparam int SHIFT_100 = 19;
    localparam logic [13:0] RECIP_10 = 14'd6554;
    localparam int SHIFT_10 = 16;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic                   kind;
        logic [2:0]             active;
        logic [DIGITS-1:0][3:0] digits;
    } msd_cmd_t;

    function automatic logic [6:0] seg_of(input digit_t d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/multiplexed_seven_segment_driver.sv */
// Four-digit common-cathode seven-segment driver. Each input beat is either a timer tick
// (kind 0) or a load of a new binary number (kind 1), and each one yields exactly one output
// beat carrying the segment pattern and the one-hot enable of the digit lit after it (both
// zero on a blank display). Loads above 9999 blank the display, and leading zeros are
// suppressed. A new beat is taken every clock cycle while the queue has room; a beat passes
// through the front register, where the decimal split is done, the command queue and the
// output register, and the queue lets the input side keep running while the output side is
// stalled, until the queue fills.
// The dwell register is written with cfg_write_en, takes effect from the next beat on, and
// resets to 5; a dwell of zero behaves as one.
`default_nettype none

module multiplexed_seven_segment_driver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_write_en,
    input  wire [9:0]  cfg_write_data,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire        kind,
    input  wire [15:0] value,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [6:0] segments,
    output logic [3:0] digit_enable
);
    import msd_pkg::*;

    logic     push_valid;
    logic     push_ready;
    msd_cmd_t push_cmd;
    logic     pop_valid;
    logic     pop_ready;
    msd_cmd_t pop_cmd;

    msd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    msd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    msd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_cmd        (pop_cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .segments       (segments),
        .digit_enable   (digit_enable)
    );

endmodule

`default_nettype wire

/* design/msd_front.sv */
`default_nettype none

module msd_front (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire                kind,
    input  wire [15:0]         value,
    output logic               push_valid,
    input  wire                push_ready,
    output msd_pkg::msd_cmd_t  push_cmd
);
    import msd_pkg::*;

    logic        valid_reg;
    logic        kind_reg;
    logic        over_reg;
    logic [2:0]  active_reg;
    logic [13:0] v_reg;
    logic [3:0]  q1000_reg;
    logic [6:0]  q100_reg;
    logic [9:0]  q10_reg;

    logic [27:0] p1000;
    logic [27:0] p100;
    logic [27:0] p10;
    logic        over_next;
    logic [2:0]  active_next;
    logic [6:0]  d2_wide;
    logic [9:0]  d1_wide;
    logic [13:0] d0_wide;

    assign in_ready = !valid_reg || push_ready;

    // The quotients are taken by reciprocal multiplication; they are exact below 10000.
    assign p1000 = 28'(value[13:0]) * 28'(RECIP_1000);
    assign p100  = 28'(value[13:0]) * 28'(RECIP_100);
    assign p10   = 28'(value[13:0]) * 28'(RECIP_10);

    assign over_next = value > MAX_VALUE;

    always_comb
    begin
        if (over_next)
        begin
            active_next = 3'd0;
        end
        else if (value >= 16'd1000)
        begin
            active_next = 3'd4;
        end
        else if (value >= 16'd100)
        begin
            active_next = 3'd3;
        end
        else if (value >= 16'd10)
        begin
            active_next = 3'd2;
        end
        else
        begin
            active_next = 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg   <= kind;
            over_reg   <= over_next;
            active_reg <= active_next;
            v_reg      <= value[13:0];
            q1000_reg  <= p1000[SHIFT_1000+3:SHIFT_1000];
            q100_reg   <= p100[SHIFT_100+6:SHIFT_100];
            q10_reg    <= p10[SHIFT_10+9:SHIFT_10];
        end
    end

    assign d2_wide = q100_reg - ({q1000_reg, 3'b000} + {2'b00, q1000_reg, 1'b0});
    assign d1_wide = q10_reg - ({q100_reg, 3'b000} + {2'b00, q100_reg, 1'b0});
    assign d0_wide = v_reg - ({1'b0, q10_reg, 3'b000} + {3'b000, q10_reg, 1'b0});

    always_comb
    begin
        push_valid      = valid_reg;
        push_cmd.kind   = kind_reg;
        push_cmd.active = active_reg;
        if (over_reg)
        begin
            push_cmd.digits = '0;
        end
        else
        begin
            push_cmd.digits[3] = q1000_reg;
            push_cmd.digits[2] = d2_wide[3:0];
            push_cmd.digits[1] = d1_wide[3:0];
            push_cmd.digits[0] = d0_wide[3:0];
        end
    end

endmodule

`default_nettype wire

/* design/msd_queue.sv */
`default_nettype none

module msd_queue #(
    parameter int DEPTH = 2
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push_valid,
    output logic               push_ready,
    input  msd_pkg::msd_cmd_t  push_cmd,
    output logic               pop_valid,
    input  wire                pop_ready,
    output msd_pkg::msd_cmd_t  pop_cmd
);
    import msd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    msd_cmd_t       entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/msd_back.sv */
`default_nettype none

module msd_back (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_write_en,
    input  wire [9:0]          cfg_write_data,
    input  wire                pop_valid,
    output logic               pop_ready,
    input  msd_pkg::msd_cmd_t  pop_cmd,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [6:0]         segments,
    output logic [3:0]         digit_enable
);
    import msd_pkg::*;

    logic [9:0]             dwell_reg;
    logic [DIGITS-1:0][3:0] digits_reg;
    logic [DIGITS-1:0][3:0] digits_next;
    logic [2:0]             active_reg;
    logic [2:0]             active_next;
    logic [1:0]             pos_reg;
    logic [1:0]             pos_next;
    logic [9:0]             count_reg;
    logic [9:0]             count_next;
    logic                   out_valid_reg;
    logic [6:0]             seg_reg;
    logic [3:0]             en_reg;

    logic [9:0]  limit;
    logic [10:0] count_inc;
    logic [2:0]  pos_inc;
    logic        fire;

    assign pop_ready    = !out_valid_reg || out_ready;
    assign fire         = pop_valid && pop_ready;
    assign out_valid    = out_valid_reg;
    assign segments     = seg_reg;
    assign digit_enable = en_reg;

    assign limit     = (dwell_reg == 10'd0) ? 10'd1 : dwell_reg;
    assign count_inc = {1'b0, count_reg} + 11'd1;
    assign pos_inc   = {1'b0, pos_reg} + 3'd1;

    always_comb
    begin
        digits_next = digits_reg;
        active_next = active_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        if (pop_cmd.kind == KIND_LOAD)
        begin
            digits_next = pop_cmd.digits;
            active_next = pop_cmd.active;
            pos_next    = 2'd0;
            count_next  = 10'd0;
        end
        else if (active_reg != 3'd0)
        begin
            if (count_inc >= {1'b0, limit})
            begin
                count_next = 10'd0;
                pos_next   = (pos_inc >= active_reg) ? 2'd0 : pos_inc[1:0];
            end
            else
            begin
                count_next = count_inc[9:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg     <= DWELL_RESET;
            digits_reg    <= '0;
            active_reg    <= 3'd0;
            pos_reg       <= 2'd0;
            count_reg     <= 10'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                dwell_reg <= cfg_write_data;
            end
            if (fire)
            begin
                digits_reg    <= digits_next;
                active_reg    <= active_next;
                pos_reg       <= pos_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (active_next == 3'd0)
            begin
                seg_reg <= 7'd0;
                en_reg  <= 4'd0;
            end
            else
            begin
                seg_reg <= seg_of(digits_next[pos_next]);
                en_reg  <= 4'd1 << pos_next;
            end
        end
    end

endmodule

`default_nettype wire

/* design/msd_checker.sv */
`default_nettype none

module msd_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        kind,
    input wire [15:0] value,
    input wire        out_valid,
    input wire        out_ready,
    input wire [6:0]  segments,
    input wire [3:0]  digit_enable
);

    // A waiting input beat must hold its payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(value))
        else $error("input beat changed while waiting");

    // A stalled output beat must hold its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(segments) && $stable(digit_enable))
        else $error("output beat changed while stalled");

    a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(digit_enable))
        else $error("more than one digit enabled");

    a_blank_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digit_enable == 4'd0 |-> segments == 7'd0)
        else $error("segments lit on a blank display");

    // Every decimal digit lights at least one segment.
    a_lit_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digit_enable != 4'd0 |-> segments != 7'd0)
        else $error("enabled digit shows no segments");

endmodule

bind multiplexed_seven_segment_driver msd_checker u_msd_checker (.*);

`default_nettype wire

/* tb/tb_multiplexed_seven_segment_driver.sv */
`timescale 1ns / 100ps

typedef struct packed {
    logic [6:0] seg;
    logic [3:0] en;
} frame_t;

class display_scoreboard;
    logic [9:0] dwell;
    logic [3:0] digit_val [4];
    logic [6:0] glyph [10];
    int lit_count;
    int scan;
    int dwell_spent;
    frame_t expected_frames [$];
    int failures;
    int reported;

    function new();
        glyph = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
        dwell = msd_pkg::DWELL_RESET;
        foreach (digit_val[i])
        begin
            digit_val[i] = '0;
        end
        lit_count = 0;
        scan = 0;
        dwell_spent = 0;
        failures = 0;
        reported = 0;
    endfunction

    function void set_dwell(logic [9:0] d);
        dwell = d;
    endfunction

    function void flag(string msg);
        failures++;
        if (reported < 10)
        begin
            reported++;
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function void note_beat(logic k, logic [15:0] v);
        int n;
        int limit;
        frame_t f;
        n = int'(v);
        if (k == msd_pkg::KIND_LOAD)
        begin
            scan = 0;
            dwell_spent = 0;
            if (v > msd_pkg::MAX_VALUE)
            begin
                foreach (digit_val[i])
                begin
                    digit_val[i] = '0;
                end
                lit_count = 0;
            end
            else
            begin
                digit_val[3] = 4'(n / 1000);
                digit_val[2] = 4'((n / 100) % 10);
                digit_val[1] = 4'((n / 10) % 10);
                digit_val[0] = 4'(n % 10);
                lit_count = n >= 1000 ? 4 : n >= 100 ? 3 : n >= 10 ? 2 : 1;
            end
        end
        else if (lit_count != 0)
        begin
            limit = (dwell == 10'd0) ? 1 : int'(dwell);
            if (dwell_spent + 1 >= limit)
            begin
                dwell_spent = 0;
                scan++;
                if (scan >= lit_count)
                begin
                    scan = 0;
                end
            end
            else
            begin
                dwell_spent++;
            end
        end
        if (lit_count == 0)
        begin
            f = '0;
        end
        else
        begin
            f.seg = glyph[digit_val[scan]];
            f.en = 4'b0001 << scan;
        end
        expected_frames.push_back(f);
    endfunction

    function void check_beat(logic [6:0] seg, logic [3:0] en);
        frame_t want;
        if (expected_frames.size() == 0)
        begin
            flag($sformatf("unexpected output beat: segments=%h digit_enable=%h", seg, en));
        end
        else
        begin
            want = expected_frames.pop_front();
            if (want.seg !== seg || want.en !== en)
            begin
                flag($sformatf("segments expected %h got %h, digit_enable expected %h got %h",
                               want.seg, seg, want.en, en));
            end
        end
    endfunction
endclass

module tb_multiplexed_seven_segment_driver;

    localparam int CYCLE_LIMIT = 200_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [9:0]  cfg_write_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = msd_pkg::KIND_TICK;
    logic [15:0] value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  segments;
    logic [3:0]  digit_enable;

    display_scoreboard board;
    int burst_left = 0;
    int cycle_count = 0;
    int rcv_count = 0;

    multiplexed_seven_segment_driver i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .segments       (segments),
        .digit_enable   (digit_enable)
    );

    always #5 clk = ~clk;

    // The receiver cycles through four stall patterns in turn.
    always @(posedge clk)
    begin
        rcv_count++;
        case ((rcv_count / 256) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (rcv_count % 5 == 0);
            default: out_ready <= ((rcv_count % 16) < 10);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.check_beat(segments, digit_enable);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("multiplexed_seven_segment_driver: mismatch");
        $finish;
    end

    task automatic send_beat(input logic k, input logic [15:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        kind <= k;
        value <= v;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        board.note_beat(k, v);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_beat(msd_pkg::KIND_TICK, 16'($urandom_range(0, 65535)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_dwell(input logic [9:0] d);
        cfg_write_en <= 1'b1;
        cfg_write_data <= d;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cfg_write_data <= 10'($urandom_range(0, 1023));
        board.set_dwell(d);
    endtask

    task automatic run_random(input int count);
        int pick;
        logic [15:0] v;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                send_ticks(1);
            end
            else
            begin
                pick = $urandom_range(0, 19);
                case (pick)
                    0, 1, 2, 3: v = 16'($urandom_range(0, 9));
                    4, 5, 6, 7: v = 16'($urandom_range(10, 99));
                    8, 9, 10, 11: v = 16'($urandom_range(100, 999));
                    12, 13, 14, 15: v = 16'($urandom_range(1000, 9999));
                    16: v = 16'($urandom_range(10000, 10010));
                    default: v = 16'($urandom_range(0, 65535));
                endcase
                send_beat(msd_pkg::KIND_LOAD, v);
            end
        end
        drain();
    endtask

    initial
    begin
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset dwell: blank ticks, single digit, then a two-digit scan.
        send_ticks(1);
        send_beat(msd_pkg::KIND_LOAD, 16'd0);
        send_ticks(5);
        send_beat(msd_pkg::KIND_LOAD, 16'd12);
        send_ticks(5);
        drain();

        // A dwell of zero advances on every tick.
        write_dwell(10'd0);
        send_beat(msd_pkg::KIND_LOAD, 16'd9999);
        send_ticks(4);
        send_beat(msd_pkg::KIND_LOAD, 16'd10000);
        send_ticks(1);
        send_beat(msd_pkg::KIND_LOAD, 16'hFFFF);
        send_beat(msd_pkg::KIND_LOAD, 16'd100);
        send_ticks(3);
        send_beat(msd_pkg::KIND_LOAD, 16'd1000);
        drain();

        // Longest dwell, then a lower dwell below the ticks already spent.
        write_dwell(10'h3FF);
        send_beat(msd_pkg::KIND_LOAD, 16'd4321);
        send_ticks(30);
        drain();
        write_dwell(10'd3);
        send_ticks(4);
        drain();

        write_dwell(10'd1);
        run_random(100);
        write_dwell(10'd0);
        run_random(90);
        write_dwell(10'd2);
        run_random(90);
        write_dwell(10'($urandom_range(3, 7)));
        run_random(120);
        write_dwell(10'($urandom_range(8, 1023)));
        run_random(40);
        write_dwell(10'd1);
        run_random(100);

        repeat (10) @(posedge clk);
        if (board.expected_frames.size() != 0)
        begin
            board.flag($sformatf("%0d output beats never arrived",
                                 board.expected_frames.size()));
        end
        if (board.failures == 0)
        begin
            $display("multiplexed_seven_segment_driver: match");
        end
        else
        begin
            $display("multiplexed_seven_segment_driver: mismatch");
        end
        $finish;
    end

endmodule
